### rtl/core/dqc_pkg.sv
package dqc_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_DUMP       = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    BS_IDLE = 1'b0,
    BS_READ = 1'b1
  } back_state_e;

  typedef struct packed {
    op_e                      op;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

endpackage

### rtl/core/double_ended_queue_core.sv
// A push passes the command queue and output register; a pop or a dump's first element
// also the registered store read. Without output stall: one push per cycle; a dump of N
// elements gives one per cycle after its first; pops and dumps block later commands.
// Reset (rst_ni low, asynchronous): front index, occupancy, command queue and output
// register clear; store contents stay undefined and need no clearing pass.
module double_ended_queue_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        mode_i,
  input  logic signed [dqc_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic signed [dqc_pkg::DATA_W-1:0] element_o,
  output logic                              last_o
);

  logic          cmdq_full;
  logic          cmdq_push;
  dqc_pkg::cmd_t front_cmd;
  logic          cmdq_valid;
  dqc_pkg::cmd_t back_cmd;
  logic          cmdq_pop;

  dqc_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .cmdq_full_i (cmdq_full),
    .cmdq_push_o (cmdq_push),
    .cmd_o       (front_cmd)
  );

  dqc_cmd_fifo u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmdq_push),
    .cmd_i   (front_cmd),
    .full_o  (cmdq_full),
    .valid_o (cmdq_valid),
    .cmd_o   (back_cmd),
    .pop_i   (cmdq_pop)
  );

  dqc_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmdq_valid),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmdq_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .element_o   (element_o),
    .last_o      (last_o)
  );

endmodule

### rtl/core/dqc_front.sv
module dqc_front (
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        mode_i,
  input  logic signed [dqc_pkg::DATA_W-1:0] value_i,
  input  logic                              cmdq_full_i,
  output logic                              cmdq_push_o,
  output dqc_pkg::cmd_t                     cmd_o
);

  logic mode_ok;

  // drop unused codes at the door
  always_comb begin
    case (dqc_pkg::op_e'(mode_i))
      dqc_pkg::OP_PUSH_FRONT,
      dqc_pkg::OP_PUSH_REAR,
      dqc_pkg::OP_POP_FRONT,
      dqc_pkg::OP_POP_REAR,
      dqc_pkg::OP_DUMP: mode_ok = 1'b1;
      default:          mode_ok = 1'b0;
    endcase
  end

  assign in_stall_o   = cmdq_full_i;
  assign cmdq_push_o  = in_valid_i && !cmdq_full_i && mode_ok;
  assign cmd_o.op     = dqc_pkg::op_e'(mode_i);
  assign cmd_o.value  = value_i;

endmodule

### rtl/core/dqc_cmd_fifo.sv
module dqc_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dqc_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          valid_o,
  output dqc_pkg::cmd_t cmd_o,
  input  logic          pop_i
);

  dqc_pkg::cmd_t entries_q [2];
  logic          wptr_q;
  logic          rptr_q;
  logic [1:0]    count_q;
  logic [1:0]    count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = entries_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wptr_q] <= cmd_i;
    end
  end

endmodule

### rtl/core/dqc_back.sv
module dqc_back #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  input  dqc_pkg::cmd_t                     cmd_i,
  output logic                              cmd_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic signed [dqc_pkg::DATA_W-1:0] element_o,
  output logic                              last_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = IW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  function automatic logic [IW-1:0] wrap(input logic [SW-1:0] pos);
    wrap = (pos >= DEPTH_S) ? IW'(pos - DEPTH_S) : IW'(pos);
  endfunction

  logic [dqc_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [dqc_pkg::DATA_W-1:0] rdata_q;

  dqc_pkg::back_state_e state_q, state_d;
  logic [IW-1:0] front_q, front_d;
  logic [CW-1:0] occ_q, occ_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic          rlast_q, rlast_d;

  logic                              out_valid_q;
  dqc_pkg::status_e                  status_q;
  logic signed [dqc_pkg::DATA_W-1:0] element_q;
  logic                              last_q;

  logic                             out_free;
  logic                             full;
  logic                             empty;
  logic                             take;
  logic [IW-1:0]                    front_dec;
  logic [IW-1:0]                    front_inc;
  logic [IW-1:0]                    rear_wr;
  logic [IW-1:0]                    rear_rd;
  logic [IW-1:0]                    dump_nxt;

  logic                             we;
  logic [IW-1:0]                    waddr;
  logic                             re;
  logic [IW-1:0]                    raddr;
  logic                             ld;
  dqc_pkg::status_e                 ld_status;
  logic [dqc_pkg::DATA_W-1:0]       ld_element;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign full      = (occ_q == CW'(DEPTH));
  assign empty     = (occ_q == '0);
  assign take      = cmd_valid_i && out_free;
  assign front_dec = (front_q == '0) ? LAST_IDX : front_q - IW'(1);
  assign front_inc = wrap(SW'(front_q) + SW'(1));
  assign rear_wr   = wrap(SW'(front_q) + SW'(occ_q));
  assign rear_rd   = wrap(SW'(front_q) + SW'(occ_q) - SW'(1));
  assign dump_nxt  = wrap(SW'(front_q) + SW'(cnt_q) + SW'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      dqc_pkg::BS_IDLE: begin
        if (take && !empty &&
            (cmd_i.op == dqc_pkg::OP_POP_FRONT || cmd_i.op == dqc_pkg::OP_POP_REAR ||
             cmd_i.op == dqc_pkg::OP_DUMP)) begin
          state_d = dqc_pkg::BS_READ;
        end
      end
      dqc_pkg::BS_READ: begin
        if (out_free && rlast_q) begin
          state_d = dqc_pkg::BS_IDLE;
        end
      end
      default: state_d = dqc_pkg::BS_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o  = 1'b0;
    we         = 1'b0;
    waddr      = front_q;
    re         = 1'b0;
    raddr      = front_q;
    front_d    = front_q;
    occ_d      = occ_q;
    cnt_d      = cnt_q;
    rlast_d    = rlast_q;
    ld         = 1'b0;
    ld_status  = dqc_pkg::ST_OK;
    ld_element = '0;
    case (state_q)
      dqc_pkg::BS_IDLE: begin
        if (take) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            dqc_pkg::OP_PUSH_FRONT,
            dqc_pkg::OP_PUSH_REAR: begin
              ld = 1'b1;
              if (full) begin
                ld_status = dqc_pkg::ST_FULL;
              end else begin
                we    = 1'b1;
                occ_d = occ_q + CW'(1);
                if (cmd_i.op == dqc_pkg::OP_PUSH_FRONT) begin
                  waddr   = front_dec;
                  front_d = front_dec;
                end else begin
                  waddr = rear_wr;
                end
              end
            end
            dqc_pkg::OP_POP_FRONT,
            dqc_pkg::OP_POP_REAR: begin
              if (empty) begin
                ld        = 1'b1;
                ld_status = dqc_pkg::ST_EMPTY;
              end else begin
                re      = 1'b1;
                occ_d   = occ_q - CW'(1);
                rlast_d = 1'b1;
                if (cmd_i.op == dqc_pkg::OP_POP_FRONT) begin
                  raddr   = front_q;
                  front_d = front_inc;
                end else begin
                  raddr = rear_rd;
                end
              end
            end
            dqc_pkg::OP_DUMP: begin
              if (empty) begin
                ld        = 1'b1;
                ld_status = dqc_pkg::ST_EMPTY;
              end else begin
                re      = 1'b1;
                raddr   = front_q;
                cnt_d   = '0;
                rlast_d = (occ_q == CW'(1));
              end
            end
            default: begin
            end
          endcase
        end
      end
      dqc_pkg::BS_READ: begin
        if (out_free) begin
          ld         = 1'b1;
          ld_element = rdata_q;
          if (!rlast_q) begin
            re      = 1'b1;
            raddr   = dump_nxt;
            cnt_d   = cnt_q + IW'(1);
            rlast_d = (SW'(cnt_q) + SW'(2) == SW'(occ_q));
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dqc_pkg::BS_IDLE;
      front_q     <= '0;
      occ_q       <= '0;
      cnt_q       <= '0;
      rlast_q     <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= dqc_pkg::ST_OK;
      last_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      occ_q   <= occ_d;
      cnt_q   <= cnt_d;
      rlast_q <= rlast_d;
      if (ld) begin
        out_valid_q <= 1'b1;
        status_q    <= ld_status;
        last_q      <= (state_q == dqc_pkg::BS_IDLE) ? 1'b1 : rlast_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      element_q <= ld_element;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= cmd_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign element_o   = element_q;
  assign last_o      = last_q;

endmodule

### rtl/core/dqc_checker.sv
module dqc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_i,
  input logic                              out_stall_i,
  input logic [1:0]                        status_i,
  input logic signed [dqc_pkg::DATA_W-1:0] element_i,
  input logic                              last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(status_i) && $stable(element_i) && $stable(last_i))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i == dqc_pkg::ST_OK || status_i == dqc_pkg::ST_EMPTY ||
                    status_i == dqc_pkg::ST_FULL)
    else $error("undefined status code");

  a_non_ok_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != dqc_pkg::ST_OK |-> element_i == '0 && last_i)
    else $error("empty or full result carries data or is not last");

endmodule

bind double_ended_queue_core dqc_checker u_dqc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_i    (status_o),
  .element_i   (element_o),
  .last_i      (last_o)
);

### sim/deque_result_checker.sv
`timescale 1ns / 100ps

module deque_result_checker
  import dqc_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [2:0]                mode_i,
  input  logic signed [DATA_W-1:0]  value_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [1:0]                status_i,
  input  logic signed [DATA_W-1:0]  element_i,
  input  logic                      last_i,
  output int unsigned               error_count_o,
  output int unsigned               pending_o
);

  typedef struct {
    status_e                  status;
    logic signed [DATA_W-1:0] element;
    logic                     last;
  } deque_result_t;

  deque_result_t            expected_results[$];
  deque_result_t            oldest;
  logic signed [DATA_W-1:0] deque_store[DEPTH];
  int unsigned              deque_front;
  int unsigned              deque_count;

  task automatic report_mismatch(input string what);
    error_count_o++;
    $display("%0t deque_result_checker: %s", $time, what);
  endtask

  task automatic predict_request(input logic [2:0] mode, input logic signed [DATA_W-1:0] value);
    int unsigned slot;
    case (mode)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (deque_count >= DEPTH) begin
          expected_results.push_back('{ST_FULL, '0, 1'b1});
        end else begin
          if (mode == OP_PUSH_FRONT) begin
            deque_front = (deque_front + DEPTH - 1) % DEPTH;
            slot = deque_front;
          end else begin
            slot = (deque_front + deque_count) % DEPTH;
          end
          deque_store[slot] = value;
          deque_count++;
          expected_results.push_back('{ST_OK, '0, 1'b1});
        end
      end
      OP_POP_FRONT: begin
        if (deque_count == 0) begin
          expected_results.push_back('{ST_EMPTY, '0, 1'b1});
        end else begin
          expected_results.push_back('{ST_OK, deque_store[deque_front], 1'b1});
          deque_front = (deque_front + 1) % DEPTH;
          deque_count--;
        end
      end
      OP_POP_REAR: begin
        if (deque_count == 0) begin
          expected_results.push_back('{ST_EMPTY, '0, 1'b1});
        end else begin
          slot = (deque_front + deque_count - 1) % DEPTH;
          expected_results.push_back('{ST_OK, deque_store[slot], 1'b1});
          deque_count--;
        end
      end
      OP_DUMP: begin
        if (deque_count == 0) begin
          expected_results.push_back('{ST_EMPTY, '0, 1'b1});
        end else begin
          for (int unsigned i = 0; i < deque_count; i++) begin
            slot = (deque_front + i) % DEPTH;
            expected_results.push_back('{ST_OK, deque_store[slot], i + 1 == deque_count});
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deque_front = 0;
      deque_count = 0;
      expected_results.delete();
      pending_o = 0;
      error_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result: status %0d element %0d last %0b",
                                    status_i, element_i, last_i));
        end else begin
          oldest = expected_results.pop_front();
          if (status_i !== oldest.status) begin
            report_mismatch($sformatf("status %0d, want %0d", status_i, oldest.status));
          end
          if (element_i !== oldest.element) begin
            report_mismatch($sformatf("element %0d, want %0d", element_i, oldest.element));
          end
          if (last_i !== oldest.last) begin
            report_mismatch($sformatf("last %0b, want %0b", last_i, oldest.last));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_request(mode_i, value_i);
      end
      pending_o = expected_results.size();
    end
  end

endmodule

### sim/tb_double_ended_queue_core.sv
`timescale 1ns / 100ps

module tb_double_ended_queue_core;
  import dqc_pkg::*;

  localparam int unsigned DEPTH         = 16;
  localparam int unsigned RANDOM_ITEMS  = 385;
  localparam int unsigned MAX_WAIT      = 17;
  localparam int unsigned LONG_HOLD     = 250;
  localparam int unsigned IDLE_LIMIT    = 3000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned RESET_CYCLES  = 7;

  localparam logic [2:0] MODE_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] MODE_LAST_UNUSED  = 3'd7;

  typedef enum int {PACE_NONE, PACE_FULL, PACE_SPARSE} pace_e;
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid;
  logic                     in_stall;
  logic [2:0]               mode;
  logic signed [DATA_W-1:0] value;
  logic                     out_valid;
  logic                     out_stall;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] element;
  logic                     last;
  int unsigned              error_count;
  int unsigned              pending;

  pace_e send_pace;
  pace_e recv_pace;
  logic  long_hold_req;

  double_ended_queue_core #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .mode_i     (mode),
    .value_i    (value),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .status_o   (status),
    .element_o  (element),
    .last_o     (last)
  );

  deque_result_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .mode_i       (mode),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .status_i     (status),
    .element_i    (element),
    .last_i       (last),
    .error_count_o(error_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic int unsigned draw_wait(input pace_e pace);
    case (pace)
      PACE_FULL:   return $urandom_range(0, MAX_WAIT);
      PACE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
      default:     return 0;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] draw_value();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(DATA_W-1){1'b1}}};
      1:       return {1'b1, {(DATA_W-1){1'b0}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic [2:0] m, input logic signed [DATA_W-1:0] v);
    int unsigned gap;
    gap = draw_wait(send_pace);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    mode     <= m;
    value    <= v;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    idle_input();
    while (pending != 0) @(negedge clk_i);
  endtask

  // receiver: draw a hold per transfer, honor one long hold-off on request
  initial begin
    int unsigned hold;
    out_stall = 1'b1;
    @(posedge rst_ni);
    forever begin
      hold = draw_wait(recv_pace);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!(out_valid && !out_stall));
      @(negedge clk_i);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_double_ended_queue_core: done, errors");
    $finish;
  end

  initial begin
    logic signed [DATA_W-1:0] corners[4];
    int unsigned              cuts[4];
    int unsigned              sent;
    int unsigned              burst_len;
    int unsigned              burst_no;
    int unsigned              roll;
    mix_e                     mix;
    logic [2:0]               m;

    in_valid      = 1'b0;
    mode          = '0;
    value         = '0;
    long_hold_req = 1'b0;
    send_pace     = PACE_FULL;
    recv_pace     = PACE_SPARSE;
    rst_ni        = 1'b0;
    corners[0] = {1'b0, {(DATA_W-1){1'b1}}};
    corners[1] = {1'b1, {(DATA_W-1){1'b0}}};
    corners[2] = '0;
    corners[3] = '1;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty queue answers
    send_request(OP_POP_FRONT, corners[3]);
    send_request(OP_POP_REAR, corners[0]);
    send_request(OP_DUMP, corners[1]);
    // fill from both ends, then overflow, dump, pop both ends and send unused modes
    for (int i = 0; i < DEPTH; i++) begin
      send_request((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_REAR,
                   (i < 4) ? corners[i] : draw_value());
    end
    send_request(OP_PUSH_FRONT, corners[0]);
    send_request(OP_PUSH_REAR, corners[1]);
    send_request(OP_DUMP, '0);
    send_request(OP_POP_FRONT, '0);
    send_request(OP_POP_REAR, '0);
    send_request(MODE_FIRST_UNUSED, corners[3]);
    send_request(MODE_LAST_UNUSED, corners[0]);

    sent     = 0;
    burst_no = 0;
    while (sent < RANDOM_ITEMS) begin
      burst_len = $urandom_range(16, 32);
      mix       = mix_e'($urandom_range(0, 2));
      send_pace = pace_e'($urandom_range(0, 2));
      recv_pace = pace_e'($urandom_range(0, 2));
      if (burst_no == 3) begin
        // back up the output side so the input stalls
        mix           = MIX_FILL;
        send_pace     = PACE_NONE;
        burst_len     = 48;
        long_hold_req = 1'b1;
      end
      if (burst_no % 5 == 4) begin
        wait_drained();
      end
      case (mix)
        MIX_FILL:  cuts = '{40, 75, 83, 91};
        MIX_DRAIN: cuts = '{12, 21, 55, 89};
        default:   cuts = '{26, 49, 70, 91};
      endcase
      repeat (burst_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          m = 3'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST_UNUSED));
        end else if (roll < cuts[0]) begin
          m = OP_PUSH_FRONT;
        end else if (roll < cuts[1]) begin
          m = OP_PUSH_REAR;
        end else if (roll < cuts[2]) begin
          m = OP_POP_FRONT;
        end else if (roll < cuts[3]) begin
          m = OP_POP_REAR;
        end else begin
          m = OP_DUMP;
        end
        send_request(m, draw_value());
        if (m <= OP_DUMP) begin
          sent++;
        end
      end
      burst_no++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("tb_double_ended_queue_core: done, clean");
    end else begin
      $display("tb_double_ended_queue_core: done, errors");
    end
    $finish;
  end

endmodule
